[sv/t8pwm_pkg.sv]
// shared types, codes and constants of the 8-bit pwm timer
package t8pwm_pkg;

   localparam int unsigned COUNT_WIDTH_DEF = 8;
   localparam int unsigned VALUE_WIDTH     = 8;
   localparam int unsigned PRE_WIDTH       = 10;
   localparam int unsigned CSR_IDX_WIDTH   = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 8;
   localparam int unsigned REQ_DATA_WIDTH  = 8;
   localparam int unsigned REQ_USER_WIDTH  = 2;
   localparam int unsigned RSP_DATA_WIDTH  = 16;

   localparam logic [2:0] CS_MASK = 3'h7;

   typedef enum logic [1:0] {
      OP_TICK          = 2'd0,
      OP_WRITE_COUNT   = 2'd1,
      OP_WRITE_COMPARE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      TM_NORMAL    = 2'd0,
      TM_PHASE_PWM = 2'd1,
      TM_CTC       = 2'd2,
      TM_FAST_PWM  = 2'd3
   } timer_mode_type;

   typedef enum logic [1:0] {
      OM_OFF    = 2'd0,
      OM_TOGGLE = 2'd1,
      OM_CLEAR  = 2'd2,
      OM_SET    = 2'd3
   } output_mode_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      REG_TIMER_MODE   = 3'd0,
      REG_OUTPUT_MODE  = 3'd1,
      REG_CLOCK_SELECT = 3'd2,
      REG_OVF_IRQ_EN   = 3'd3,
      REG_CMP_IRQ_EN   = 3'd4
   } reg_index_type;

   typedef struct packed {
      timer_mode_type  timer_mode;
      output_mode_type output_mode;
      logic [2:0]      clock_select;
      logic            overflow_irq_enable;
      logic            compare_irq_enable;
   } cfg_type;

   typedef struct packed {
      logic                   compare_irq;
      logic                   overflow_irq;
      logic                   compare_event;
      logic                   overflow_event;
      logic                   pin_level;
      logic [VALUE_WIDTH-1:0] count_value;
   } rsp_type;

   // prescaler division ratio; select 0 is never used (timer stopped)
   function automatic logic [PRE_WIDTH:0] divisor(input logic [2:0] sel);
      logic [PRE_WIDTH:0] d;
      unique case (sel)
         3'd1:    d = (PRE_WIDTH+1)'(1);
         3'd2:    d = (PRE_WIDTH+1)'(8);
         3'd3:    d = (PRE_WIDTH+1)'(32);
         3'd4:    d = (PRE_WIDTH+1)'(64);
         3'd5:    d = (PRE_WIDTH+1)'(128);
         3'd6:    d = (PRE_WIDTH+1)'(256);
         3'd7:    d = (PRE_WIDTH+1)'(1024);
         default: d = '0;
      endcase
      return d;
   endfunction

endpackage

[sv/t8pwm_timer.sv]
// timer state registers with the per-item next-state and result logic
module t8pwm_timer #(
   parameter int unsigned COUNT_WIDTH = t8pwm_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   accept,
   input  t8pwm_pkg::cfg_type                     cfg,
   input  logic [t8pwm_pkg::REQ_USER_WIDTH-1:0]   operation,
   input  logic [t8pwm_pkg::VALUE_WIDTH-1:0]      write_value,
   output t8pwm_pkg::rsp_type                     result
);
   import t8pwm_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

   logic [PRE_WIDTH-1:0]   prescale_ff, prescale_in;
   logic [COUNT_WIDTH-1:0] counter_ff, counter_in;
   logic [COUNT_WIDTH-1:0] active_ff, active_in;
   logic [COUNT_WIDTH-1:0] buffer_ff, buffer_in;
   logic                   down_ff, down_in;
   logic                   pin_ff, pin_in;

   logic [PRE_WIDTH:0]     pre_next;
   logic [COUNT_WIDTH-1:0] nxt;
   logic                   step;
   logic                   ovf;
   logic                   cmp;
   logic                   up_after;

   always_comb begin
      prescale_in = prescale_ff;
      counter_in  = counter_ff;
      active_in   = active_ff;
      buffer_in   = buffer_ff;
      down_in     = down_ff;
      pin_in      = pin_ff;
      ovf         = 1'b0;
      cmp         = 1'b0;
      step        = 1'b0;
      nxt         = counter_ff;
      up_after    = 1'b1;
      pre_next    = {1'b0, prescale_ff} + (PRE_WIDTH+1)'(1);

      unique case (operation)
         OP_TICK: begin
            if ((cfg.clock_select & CS_MASK) != 3'd0) begin
               if (pre_next >= divisor(cfg.clock_select)) begin
                  prescale_in = '0;
                  step        = 1'b1;
               end else begin
                  prescale_in = pre_next[PRE_WIDTH-1:0];
               end
            end
         end
         OP_WRITE_COUNT: begin
            counter_in = COUNT_WIDTH'(write_value);
         end
         OP_WRITE_COMPARE: begin
            buffer_in = COUNT_WIDTH'(write_value);
            if (cfg.timer_mode == TM_NORMAL || cfg.timer_mode == TM_CTC) begin
               active_in = COUNT_WIDTH'(write_value);
            end
         end
         default: begin
         end
      endcase

      if (step) begin
         if (cfg.timer_mode == TM_PHASE_PWM) begin
            // up/down counting, compare reload at top
            if (!down_ff) begin
               nxt = counter_ff + CNT_ONE;
               if (nxt == CNT_MAX) begin
                  down_in   = 1'b1;
                  active_in = buffer_ff;
               end
            end else begin
               nxt = counter_ff - CNT_ONE;
               if (nxt == '0) begin
                  down_in = 1'b0;
                  ovf     = 1'b1;
               end
            end
            up_after = !down_in;
         end else begin
            if (cfg.timer_mode == TM_CTC && counter_ff == active_ff) begin
               nxt = '0;
            end else begin
               nxt = counter_ff + CNT_ONE;
            end
            ovf = (counter_ff == CNT_MAX) && (nxt == '0);
            // fast pwm: reload compare and run the bottom action
            if (cfg.timer_mode == TM_FAST_PWM && nxt == '0) begin
               active_in = buffer_ff;
               if (cfg.output_mode == OM_CLEAR) begin
                  pin_in = 1'b1;
               end else if (cfg.output_mode == OM_SET) begin
                  pin_in = 1'b0;
               end
            end
         end
         counter_in = nxt;

         if (nxt == active_in) begin
            cmp = 1'b1;
            unique case (cfg.timer_mode)
               TM_NORMAL, TM_CTC: begin
                  unique case (cfg.output_mode)
                     OM_TOGGLE: pin_in = !pin_in;
                     OM_CLEAR:  pin_in = 1'b0;
                     OM_SET:    pin_in = 1'b1;
                     default:   pin_in = pin_in;
                  endcase
               end
               TM_FAST_PWM: begin
                  if (cfg.output_mode == OM_CLEAR) begin
                     pin_in = 1'b0;
                  end else if (cfg.output_mode == OM_SET) begin
                     pin_in = 1'b1;
                  end
               end
               default: begin
                  if (cfg.output_mode == OM_CLEAR) begin
                     pin_in = !up_after;
                  end else if (cfg.output_mode == OM_SET) begin
                     pin_in = up_after;
                  end
               end
            endcase
         end
      end

      result.count_value    = counter_in[VALUE_WIDTH-1:0];
      result.pin_level      = (cfg.output_mode != OM_OFF) && pin_in;
      result.overflow_event = ovf;
      result.compare_event  = cmp;
      result.overflow_irq   = ovf && cfg.overflow_irq_enable;
      result.compare_irq    = cmp && cfg.compare_irq_enable;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
         counter_ff  <= '0;
         active_ff   <= '0;
         buffer_ff   <= '0;
         down_ff     <= 1'b0;
         pin_ff      <= 1'b0;
      end else if (accept) begin
         prescale_ff <= prescale_in;
         counter_ff  <= counter_in;
         active_ff   <= active_in;
         buffer_ff   <= buffer_in;
         down_ff     <= down_in;
         pin_ff      <= pin_in;
      end
   end

endmodule

[sv/t8pwm_out_buf.sv]
// result register with a skid stage so the input side keeps flowing
module t8pwm_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  t8pwm_pkg::rsp_type   in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output t8pwm_pkg::rsp_type   out_data
);
   import t8pwm_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_data_ff, main_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    in_fire;
   logic    out_fire;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign out_valid = main_valid_ff;
   assign out_fire  = main_valid_ff && out_ready;
   assign out_data  = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (out_fire) begin
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (in_fire) begin
            main_data_in = in_data;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (in_fire) begin
         if (!main_valid_ff) begin
            main_data_in  = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

[sv/timer8_pwm_compare_unit_core.sv]
// top level of the 8-bit timer/counter with compare output and pwm
//
// usage:
//  - req channel: one item per handshake; tuser carries the operation
//    (tick, counter write, compare write), tdata the write value
//  - rsp channel: exactly one result item per request item, in order:
//    count, pin level, overflow/compare events and gated irq lines
//  - csr channel: register index plus data; always ready, one write per
//    cycle, to be used only while no item is in flight
//  - each result is registered as its request item is taken (result register or skid stage)
//  - throughput: one item per cycle while req_tready is high; the whole timer
//    update is one pass of logic between the state registers and the result register
//  - a stalled receiver is absorbed by a skid stage; req_tready drops only
//    when both the result register and the skid stage hold items
//  - reset (synchronous, active high) clears the valid flags, the configuration
//    and the timer state; no clearing pass, the block takes items the cycle after reset
module timer8_pwm_compare_unit_core #(
   parameter int unsigned COUNT_WIDTH = t8pwm_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request items
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // [7:0] write_value
   input  logic [t8pwm_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   // [1:0] operation
   input  logic [t8pwm_pkg::REQ_USER_WIDTH-1:0]    req_tuser,
   // result items
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // [7:0] count_value, [8] pin_level, [9] overflow_event,
   // [10] compare_event, [11] overflow_irq, [12] compare_irq, [15:13] zero
   output logic [t8pwm_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   // register writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [t8pwm_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic [t8pwm_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import t8pwm_pkg::*;

   localparam int unsigned RSP_BITS = $bits(rsp_type);

   cfg_type cfg_ff, cfg_in;
   rsp_type step_result;
   rsp_type out_result;
   logic    req_accept;

   // configuration registers, writes beyond the list fall through
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_TIMER_MODE:   cfg_in.timer_mode          = timer_mode_type'(csr_wdata[1:0]);
            REG_OUTPUT_MODE:  cfg_in.output_mode         = output_mode_type'(csr_wdata[1:0]);
            REG_CLOCK_SELECT: cfg_in.clock_select        = csr_wdata[2:0] & CS_MASK;
            REG_OVF_IRQ_EN:   cfg_in.overflow_irq_enable = csr_wdata[0];
            REG_CMP_IRQ_EN:   cfg_in.compare_irq_enable  = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{timer_mode: TM_NORMAL, output_mode: OM_OFF, clock_select: 3'd0,
                     overflow_irq_enable: 1'b0, compare_irq_enable: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // timer state advances at the edge where the item is taken
   assign req_accept = req_tvalid && req_tready;

   t8pwm_timer #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_timer (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .cfg         (cfg_ff),
      .operation   (req_tuser),
      .write_value (req_tdata[VALUE_WIDTH-1:0]),
      .result      (step_result)
   );

   t8pwm_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (step_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_result)
   );

   // struct packs count in the low bits, flags above, pad to whole bytes
   assign rsp_tdata = {{(RSP_DATA_WIDTH-RSP_BITS){1'b0}}, out_result};

endmodule

[test/timer8_pwm_compare_unit_core_tb.sv]
// self-checking testbench for the 8-bit pwm timer/counter core
module timer8_pwm_compare_unit_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import t8pwm_pkg::*;

   // operation code with no function, the block must leave its state alone
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // register index past the end of the register list, writes are dropped
   localparam logic [CSR_IDX_WIDTH-1:0] REG_UNUSED = 3'd7;
   localparam logic [VALUE_WIDTH-1:0] COUNT_TOP = 8'hFF;

   localparam int unsigned RANDOM_ITEMS = 150;
   localparam int unsigned SLOW_TICKS   = 260;   // enough for one divide-by-256 step
   localparam int unsigned LONG_HOLD    = 300;   // receiver hold-off, fills the skid stage
   localparam int unsigned SETTLE       = 4;     // margin after the last result comes back
   localparam int unsigned CYCLE_LIMIT  = 600000;

   typedef struct packed {
      logic [1:0]             op;
      logic [VALUE_WIDTH-1:0] value;
   } timer_cmd_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata  = '0;
   logic [REQ_USER_WIDTH-1:0] req_tuser  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_WIDTH-1:0]  csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata  = '0;

   // commands waiting to go onto the request bus
   timer_cmd_t pending_cmds[$];
   // predicted result items, oldest first
   rsp_type    timer_results_due[$];

   // shadow copy of the timer, advanced on every accepted item
   cfg_type                shadow_cfg      = '0;
   logic [PRE_WIDTH-1:0]   shadow_prescale = '0;
   logic [VALUE_WIDTH-1:0] shadow_count    = '0;
   logic [VALUE_WIDTH-1:0] shadow_active   = '0;
   logic [VALUE_WIDTH-1:0] shadow_buffer   = '0;
   logic                   shadow_down     = 1'b0;
   logic                   shadow_pin      = 1'b0;

   logic        steady     = 1'b0;   // no random gaps on either side while set
   logic        hold_start = 1'b0;
   int unsigned hold_left  = 0;
   int unsigned send_gap   = 0;
   int unsigned stall_left = 0;
   int unsigned cycles     = 0;
   int unsigned mismatches = 0;

   timer8_pwm_compare_unit_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // pin reaction to a compare match; up is the count direction after the step
   function automatic void pin_on_match(input logic up);
      case (shadow_cfg.timer_mode)
         TM_NORMAL, TM_CTC: begin
            case (shadow_cfg.output_mode)
               OM_TOGGLE: shadow_pin = ~shadow_pin;
               OM_CLEAR:  shadow_pin = 1'b0;
               OM_SET:    shadow_pin = 1'b1;
               default: ;
            endcase
         end
         TM_FAST_PWM: begin
            // toggle is reserved in pwm modes
            if (shadow_cfg.output_mode == OM_CLEAR) shadow_pin = 1'b0;
            else if (shadow_cfg.output_mode == OM_SET) shadow_pin = 1'b1;
         end
         default: begin
            // phase correct: clear counting up / set counting down, or the inverse
            if (shadow_cfg.output_mode == OM_CLEAR) shadow_pin = ~up;
            else if (shadow_cfg.output_mode == OM_SET) shadow_pin = up;
         end
      endcase
   endfunction

   // advance the shadow timer by one item and return the result it produces
   function automatic rsp_type timer_step(input logic [1:0] op,
                                          input logic [VALUE_WIDTH-1:0] value);
      rsp_type                res;
      logic                   ovf;
      logic                   cmp;
      logic [VALUE_WIDTH-1:0] nxt;
      int unsigned            ratio;
      ovf = 1'b0;
      cmp = 1'b0;
      case (op)
         OP_TICK: begin
            case (shadow_cfg.clock_select & CS_MASK)
               3'd1:    ratio = 1;
               3'd2:    ratio = 8;
               3'd3:    ratio = 32;
               3'd4:    ratio = 64;
               3'd5:    ratio = 128;
               3'd6:    ratio = 256;
               3'd7:    ratio = 1024;
               default: ratio = 0;   // timer stopped
            endcase
            if (ratio != 0) begin
               if (shadow_prescale + 1 >= ratio) begin
                  shadow_prescale = '0;
                  if (shadow_cfg.timer_mode == TM_PHASE_PWM) begin
                     // up to top, reload compare and turn; down to bottom, overflow
                     if (!shadow_down) begin
                        nxt = shadow_count + 1'b1;
                        if (nxt == COUNT_TOP) begin
                           shadow_down   = 1'b1;
                           shadow_active = shadow_buffer;
                        end
                     end else begin
                        nxt = shadow_count - 1'b1;
                        if (nxt == '0) begin
                           shadow_down = 1'b0;
                           ovf         = 1'b1;
                        end
                     end
                     shadow_count = nxt;
                     if (shadow_count == shadow_active) begin
                        cmp = 1'b1;
                        pin_on_match(~shadow_down);
                     end
                  end else begin
                     if (shadow_cfg.timer_mode == TM_CTC && shadow_count == shadow_active)
                        nxt = '0;
                     else
                        nxt = shadow_count + 1'b1;
                     if (shadow_count == COUNT_TOP && nxt == '0) ovf = 1'b1;
                     shadow_count = nxt;
                     // fast pwm bottom: reload compare, pin to its idle level
                     if (shadow_cfg.timer_mode == TM_FAST_PWM && shadow_count == '0) begin
                        shadow_active = shadow_buffer;
                        if (shadow_cfg.output_mode == OM_CLEAR) shadow_pin = 1'b1;
                        else if (shadow_cfg.output_mode == OM_SET) shadow_pin = 1'b0;
                     end
                     if (shadow_count == shadow_active) begin
                        cmp = 1'b1;
                        pin_on_match(1'b1);
                     end
                  end
               end else begin
                  shadow_prescale = shadow_prescale + 1'b1;
               end
            end
         end
         OP_WRITE_COUNT: shadow_count = value;
         OP_WRITE_COMPARE: begin
            // double buffered in pwm modes, direct otherwise
            shadow_buffer = value;
            if (shadow_cfg.timer_mode == TM_NORMAL || shadow_cfg.timer_mode == TM_CTC)
               shadow_active = value;
         end
         default: ;
      endcase
      res.count_value    = shadow_count;
      res.pin_level      = (shadow_cfg.output_mode != OM_OFF) && shadow_pin;
      res.overflow_event = ovf;
      res.compare_event  = cmp;
      res.overflow_irq   = ovf & shadow_cfg.overflow_irq_enable;
      res.compare_irq    = cmp & shadow_cfg.compare_irq_enable;
      return res;
   endfunction

   function automatic timer_cmd_t random_cmd();
      timer_cmd_t c;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 78) c.op = OP_TICK;
      else if (r < 88) c.op = OP_WRITE_COUNT;
      else if (r < 98) c.op = OP_WRITE_COMPARE;
      else c.op = OP_UNUSED;
      // values near the ends of the range reach top, bottom and wrap quickly
      case ($urandom_range(0, 3))
         0:       c.value = VALUE_WIDTH'($urandom_range(248, 255));
         1:       c.value = VALUE_WIDTH'($urandom_range(0, 7));
         default: c.value = VALUE_WIDTH'($urandom);
      endcase
      return c;
   endfunction

   task automatic queue_cmd(input logic [1:0] op, input logic [VALUE_WIDTH-1:0] value);
      pending_cmds.push_back('{op, value});
   endtask

   task automatic csr_write(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // unused upper bits of each write carry noise, the block must ignore them
   task automatic set_config(input timer_mode_type tm, input output_mode_type om,
                             input logic [2:0] cs, input logic ovf_en, input logic cmp_en);
      csr_write(REG_TIMER_MODE,   {6'($urandom), tm});
      csr_write(REG_OUTPUT_MODE,  {6'($urandom), om});
      csr_write(REG_CLOCK_SELECT, {5'($urandom), cs});
      csr_write(REG_OVF_IRQ_EN,   {7'($urandom), ovf_en});
      csr_write(REG_CMP_IRQ_EN,   {7'($urandom), cmp_en});
   endtask

   // block is idle once every command went out and every result came back
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_tvalid || timer_results_due.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // request driver: predicts each accepted item, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid      <= 1'b0;
         send_gap        = 0;
         shadow_cfg      = '0;
         shadow_prescale = '0;
         shadow_count    = '0;
         shadow_active   = '0;
         shadow_buffer   = '0;
         shadow_down     = 1'b0;
         shadow_pin      = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TIMER_MODE:   shadow_cfg.timer_mode  = timer_mode_type'(csr_wdata[1:0]);
               REG_OUTPUT_MODE:  shadow_cfg.output_mode = output_mode_type'(csr_wdata[1:0]);
               REG_CLOCK_SELECT: shadow_cfg.clock_select = csr_wdata[2:0] & CS_MASK;
               REG_OVF_IRQ_EN:   shadow_cfg.overflow_irq_enable = csr_wdata[0];
               REG_CMP_IRQ_EN:   shadow_cfg.compare_irq_enable  = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            timer_results_due.push_back(timer_step(req_tuser, req_tdata));
         // bus is free when nothing is offered or the offered item just went in
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               timer_cmd_t c;
               c = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= c.op;
               req_tdata  <= c.value;
               send_gap   = steady ? 0 : pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, started by a one-cycle pulse
   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_start) hold_left <= LONG_HOLD;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // result monitor: compares each item against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_type seen;
            rsp_type due;
            seen = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
            if (timer_results_due.size() == 0) begin
               $error("result item with no prediction waiting, tdata %h", rsp_tdata);
               mismatches++;
            end else begin
               due = timer_results_due.pop_front();
               if (seen.count_value !== due.count_value) begin
                  $error("count_value expected %0d got %0d", due.count_value, seen.count_value);
                  mismatches++;
               end
               if (seen.pin_level !== due.pin_level) begin
                  $error("pin_level expected %0b got %0b", due.pin_level, seen.pin_level);
                  mismatches++;
               end
               if (seen.overflow_event !== due.overflow_event) begin
                  $error("overflow_event expected %0b got %0b",
                         due.overflow_event, seen.overflow_event);
                  mismatches++;
               end
               if (seen.compare_event !== due.compare_event) begin
                  $error("compare_event expected %0b got %0b",
                         due.compare_event, seen.compare_event);
                  mismatches++;
               end
               if (seen.overflow_irq !== due.overflow_irq) begin
                  $error("overflow_irq expected %0b got %0b", due.overflow_irq, seen.overflow_irq);
                  mismatches++;
               end
               if (seen.compare_irq !== due.compare_irq) begin
                  $error("compare_irq expected %0b got %0b", due.compare_irq, seen.compare_irq);
                  mismatches++;
               end
               if (rsp_tdata[RSP_DATA_WIDTH-1:$bits(rsp_type)] !== '0) begin
                  $error("padding expected 0 got %0h", rsp_tdata[RSP_DATA_WIDTH-1:$bits(rsp_type)]);
                  mismatches++;
               end
            end
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!steady && $urandom_range(0, 2) == 0) stall_left = pick_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timer8_pwm_compare_unit_core test failed");
         $finish;
      end
   end

   initial begin
      timer_mode_type  tm;
      output_mode_type om;
      logic [2:0]      cs;
      int unsigned     n;
      int unsigned     r;
      int unsigned     random_sent;
      random_sent = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: timer stopped, pin off; writes and the unused operation
      @(negedge clock);
      queue_cmd(OP_WRITE_COUNT, 8'hFF);
      queue_cmd(OP_WRITE_COMPARE, 8'h00);
      queue_cmd(OP_TICK, 8'h5A);
      queue_cmd(OP_UNUSED, 8'hAA);
      queue_cmd(OP_WRITE_COUNT, 8'h00);
      wait_idle();

      // normal mode, toggle on match, undivided clock: match at top, then wrap
      set_config(TM_NORMAL, OM_TOGGLE, 3'd1, 1'b1, 1'b1);
      csr_write(REG_UNUSED, 8'($urandom));
      @(negedge clock);
      queue_cmd(OP_WRITE_COMPARE, 8'hFF);
      queue_cmd(OP_WRITE_COUNT, 8'hFD);
      repeat (4) queue_cmd(OP_TICK, 8'h00);
      wait_idle();

      // ctc: count clears right after matching the compare value
      set_config(TM_CTC, OM_CLEAR, 3'd1, 1'b0, 1'b1);
      @(negedge clock);
      queue_cmd(OP_WRITE_COMPARE, 8'h02);
      queue_cmd(OP_WRITE_COUNT, 8'h00);
      repeat (3) queue_cmd(OP_TICK, 8'hFF);
      wait_idle();

      // phase correct: buffered compare loads at top, direction turns at both ends
      set_config(TM_PHASE_PWM, OM_SET, 3'd1, 1'b1, 1'b0);
      @(negedge clock);
      queue_cmd(OP_WRITE_COMPARE, 8'hFF);
      queue_cmd(OP_WRITE_COUNT, 8'hFD);
      repeat (3) queue_cmd(OP_TICK, 8'h00);
      queue_cmd(OP_WRITE_COUNT, 8'h01);
      queue_cmd(OP_TICK, 8'h00);
      wait_idle();

      // fast pwm: bottom action and a match at zero in the same step, match wins
      set_config(TM_FAST_PWM, OM_CLEAR, 3'd1, 1'b1, 1'b1);
      @(negedge clock);
      queue_cmd(OP_WRITE_COMPARE, 8'h00);
      queue_cmd(OP_WRITE_COUNT, 8'hFF);
      queue_cmd(OP_TICK, 8'h00);
      wait_idle();

      // back-pressure: receiver holds off while the sender keeps offering
      set_config(TM_FAST_PWM, OM_SET, 3'd1, 1'b1, 1'b1);
      @(posedge clock);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      @(negedge clock);
      steady = 1'b1;
      repeat (60) pending_cmds.push_back(random_cmd());
      wait_idle();

      // large prescaler: enough ticks for one counter step
      set_config(TM_NORMAL, OM_TOGGLE, 3'd6, 1'b1, 1'b1);
      @(negedge clock);
      queue_cmd(OP_WRITE_COUNT, 8'hFF);
      queue_cmd(OP_WRITE_COMPARE, 8'h00);
      repeat (SLOW_TICKS) queue_cmd(OP_TICK, 8'($urandom));
      wait_idle();

      // random phases, mostly small divisors so the counter moves
      while (random_sent < RANDOM_ITEMS) begin
         tm = timer_mode_type'($urandom_range(0, 3));
         om = output_mode_type'($urandom_range(0, 3));
         r  = $urandom_range(0, 99);
         if (r < 45) cs = 3'd1;
         else if (r < 70) cs = 3'd2;
         else if (r < 95) cs = 3'($urandom_range(3, 6));
         else cs = 3'($urandom_range(0, 7));
         set_config(tm, om, cs, 1'($urandom), 1'($urandom));
         n = $urandom_range(20, 80);
         @(negedge clock);
         steady = ($urandom_range(0, 4) == 0);
         repeat (n) pending_cmds.push_back(random_cmd());
         random_sent += n;
         wait_idle();
      end

      if (mismatches == 0)
         $display("timer8_pwm_compare_unit_core test passed");
      else
         $display("timer8_pwm_compare_unit_core test failed");
      $finish;
   end

endmodule
